// ===== src/hedts_pkg.sv =====
package hedts_pkg;

  localparam int MAX_REF_DEF = 12;
  localparam int QDEPTH      = 4;
  localparam logic [15:0] CAP_RESET = 16'd256;
  localparam logic [20:0] CODE_MAX  = 21'h10FFFF;
  localparam int NUM_ENT = 7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_text;
  } out_t;

  // one emitted item: up to four bytes, byte 0 first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            term;
  } cmd_t;

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    if (lead < 8'hC0) begin
      seq_len = 3'd1;
    end else if (lead < 8'hE0) begin
      seq_len = 3'd2;
    end else if (lead < 8'hF0) begin
      seq_len = 3'd3;
    end else begin
      seq_len = 3'd4;
    end
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] i);
    unique case (i)
      3'd0: ent_len = 3'd4;
      3'd1: ent_len = 3'd3;
      3'd2: ent_len = 3'd3;
      3'd3: ent_len = 3'd5;
      3'd4: ent_len = 3'd5;
      3'd5: ent_len = 3'd7;
      3'd6: ent_len = 3'd5;
      default: ent_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] ent_code(input logic [2:0] i);
    unique case (i)
      3'd0: ent_code = "&";
      3'd1: ent_code = "<";
      3'd2: ent_code = ">";
      3'd3: ent_code = "\"";
      3'd4: ent_code = "'";
      3'd5: ent_code = 8'hB7;
      3'd6: ent_code = " ";
      default: ent_code = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ent_char(input logic [2:0] i, input logic [2:0] pos);
    logic [7:0][7:0] s;
    unique case (i)
      3'd0: s = {"    ", "amp;"};
      3'd1: s = {"     ", "lt;"};
      3'd2: s = {"     ", "gt;"};
      3'd3: s = {"   ", "quot;"};
      3'd4: s = {"   ", "apos;"};
      3'd5: s = {" ", "middot;"};
      3'd6: s = {"   ", "nbsp;"};
      default: s = '0;
    endcase
    // string packs leftmost char high; text starts at byte len-1
    ent_char = s[3'(ent_len(i) - 3'd1 - pos)];
  endfunction

  function automatic cmd_t encode(input logic [20:0] cp);
    cmd_t c;
    c = '0;
    if (cp < 21'h80) begin
      c.bytes[0] = cp[7:0];
      c.len = 3'd1;
    end else if (cp < 21'h800) begin
      c.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
      c.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
      c.len = 3'd2;
    end else if (cp < 21'h10000) begin
      c.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
      c.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
      c.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
      c.len = 3'd3;
    end else begin
      c.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
      c.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
      c.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
      c.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
      c.len = 3'd4;
    end
    encode = c;
  endfunction

endpackage

// ===== src/hedts_front.sv =====
module hedts_front import hedts_pkg::*; #(
  parameter int MAX_REF = MAX_REF_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         in_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        q_push,
  output cmd_t        q_data,
  input  logic        q_full
);

  localparam int REF_LIMIT = (MAX_REF < 19) ? MAX_REF : 19;
  localparam int CW = $clog2(REF_LIMIT);

  typedef enum logic [2:0] {S_IDLE, S_AMP, S_RPL, S_REDO, S_END, S_TERM} st_t;
  typedef enum logic [2:0] {M_TEXT, M_TAG, M_REF, M_UTF, M_STOP} mode_t;

  st_t   st, st_next;
  mode_t mode, mode_next;
  logic [15:0] capacity;
  logic [7:0]  la [REF_LIMIT];
  logic [CW-1:0] cnt, cnt_next, ridx, ridx_next;
  logic [7:0]  u0, u0_next, u1, u1_next, u2, u2_next;
  logic [1:0]  urem, urem_next;
  logic [15:0] used, used_next;
  logic [20:0] val, val_next;
  logic        hex, hex_next, num, num_next;
  logic [NUM_ENT-1:0] mask, mask_next;
  logic [7:0]  cur_c, cur_c_next;
  logic        cur_last, cur_last_next, lastfail, lastfail_next;

  logic        accept, adv, la_we;
  logic        tb_act, em_req, term_req;
  logic [7:0]  tb_b, c;
  cmd_t        em;
  logic [15:0] capv;
  logic [16:0] need;
  logic        fits;

  // judge
  logic [CW:0] n2;
  logic [NUM_ENT-1:0] hit;
  logic        j_live, j_done, dig_ok;
  logic [3:0]  dig;
  logic [24:0] vx;
  logic [20:0] j_cp;
  logic [2:0]  uidx;
  logic [2:0]  ulen;
  logic [3:0][7:0] ub;

  assign cfg_ready = 1'b1;
  assign full   = (st != S_IDLE) || q_full;
  assign accept = push && !full;
  assign adv    = (st == S_IDLE) ? accept : !q_full;
  assign c      = in_item.in_byte;

  always_comb begin
    n2 = {1'b0, cnt} + (CW+1)'(2);
    j_live = 1'b0;
    j_done = 1'b0;
    j_cp   = '0;
    hit    = '0;
    dig    = '0;
    dig_ok = 1'b0;
    vx     = '0;
    if (c >= "0" && c <= "9") begin
      dig = 4'(c - "0");
      dig_ok = 1'b1;
    end else if (hex && c >= "a" && c <= "f") begin
      dig = 4'(c - "a" + 8'd10);
      dig_ok = 1'b1;
    end else if (hex && c >= "A" && c <= "F") begin
      dig = 4'(c - "A" + 8'd10);
      dig_ok = 1'b1;
    end
    vx = (hex ? {val, 4'b0} : ({1'b0, val, 3'b0} + {3'b0, val, 1'b0})) + 25'(dig);
    if (n2 > (CW+1)'(REF_LIMIT)) begin
      j_live = 1'b0;
    end else if (cnt == '0 && c == "#") begin
      j_live = 1'b1;
    end else if (num) begin
      if (c == ";") begin
        j_done = (cnt - CW'(1)) > CW'(hex);
        j_cp   = val;
      end else if (cnt == CW'(1) && (c == "x" || c == "X")) begin
        j_live = 1'b1;
      end else if (dig_ok && vx <= 25'(CODE_MAX)) begin
        j_live = 1'b1;
      end
    end else begin
      for (int i = 0; i < NUM_ENT; i++) begin
        hit[i] = mask[i] && ({{(8-CW){1'b0}}, cnt} < {5'b0, ent_len(3'(i))})
                 && ent_char(3'(i), 3'(cnt)) == c;
        if (hit[i] && {{(8-CW){1'b0}}, cnt} + 8'd1 == {5'b0, ent_len(3'(i))} && !j_done) begin
          j_done = 1'b1;
          j_cp   = {13'b0, ent_code(3'(i))};
        end
      end
      j_live = !j_done && (|hit);
    end
  end

  always_comb begin
    ulen = seq_len(u0);
    uidx = ulen - {1'b0, urem};
    ub   = {u2, u1, u0, u0};
    ub[0] = u0;
    ub[1] = u1;
    ub[2] = u2;
    ub[3] = 8'h00;
    ub[2'(ulen - 3'd1)] = c;
  end

  always_comb begin
    st_next = st;  mode_next = mode;  cnt_next = cnt;  ridx_next = ridx;
    u0_next = u0;  u1_next = u1;  u2_next = u2;  urem_next = urem;
    used_next = used;  val_next = val;  hex_next = hex;  num_next = num;
    mask_next = mask;  cur_c_next = cur_c;  cur_last_next = cur_last;
    lastfail_next = lastfail;
    la_we = 1'b0;  tb_act = 1'b0;  tb_b = '0;
    em_req = 1'b0;  em = '0;  term_req = 1'b0;
    q_push = 1'b0;  q_data = '0;

    unique case (st)
      S_IDLE: begin
        if (accept) begin
          cur_c_next    = c;
          cur_last_next = in_item.final_byte;
          lastfail_next = 1'b0;
          if (in_item.final_byte) begin
            st_next = S_END;
          end
          unique case (mode)
            M_TAG: begin
              if (c == ">") mode_next = M_TEXT;
            end
            M_UTF: begin
              if (urem > 2'd1) begin
                if (uidx == 3'd1) u1_next = c;
                else u2_next = c;
                urem_next = urem - 2'd1;
              end else begin
                urem_next = '0;
                mode_next = M_TEXT;
                em_req = 1'b1;
                em.bytes = ub;
                em.len = ulen;
              end
            end
            M_REF: begin
              if (j_live) begin
                la_we = 1'b1;
                cnt_next = cnt + CW'(1);
                mask_next = hit;
                if (cnt == '0 && c == "#") num_next = 1'b1;
                else if (num && cnt == CW'(1) && (c == "x" || c == "X")) hex_next = 1'b1;
                else if (num) val_next = vx[20:0];
              end else if (j_done) begin
                mode_next = M_TEXT;
                cnt_next = '0;
                em_req = 1'b1;
                em = encode(j_cp);
              end else begin
                st_next = S_AMP;
              end
            end
            M_TEXT: begin
              tb_act = 1'b1;
              tb_b = c;
            end
            default: ;
          endcase
        end
      end
      S_AMP: begin
        mode_next = M_TEXT;
        em_req = 1'b1;
        em.bytes[0] = "&";
        em.len = 3'd1;
        ridx_next = '0;
        if (cnt == '0) st_next = lastfail ? S_TERM : S_REDO;
        else st_next = S_RPL;
      end
      S_RPL: begin
        if (mode != M_STOP) begin
          em_req = 1'b1;
          em.bytes[0] = la[ridx];
          em.len = 3'd1;
        end
        ridx_next = ridx + CW'(1);
        if (ridx == cnt - CW'(1)) begin
          cnt_next = '0;
          st_next = lastfail ? S_TERM : S_REDO;
        end
      end
      S_REDO: begin
        tb_act = 1'b1;
        tb_b = cur_c;
        st_next = cur_last ? S_END : S_IDLE;
      end
      S_END: begin
        if (mode == M_REF) begin
          lastfail_next = 1'b1;
          st_next = S_AMP;
        end else begin
          st_next = S_TERM;
        end
      end
      S_TERM: begin
        term_req = 1'b1;
        mode_next = M_TEXT;
        cnt_next = '0;  urem_next = '0;  used_next = '0;
        val_next = '0;  hex_next = 1'b0;  num_next = 1'b0;
        st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase

    if (tb_act && mode != M_STOP) begin
      if (tb_b == "<") begin
        mode_next = M_TAG;
      end else if (tb_b == "&") begin
        mode_next = M_REF;
        cnt_next = '0;  val_next = '0;  hex_next = 1'b0;  num_next = 1'b0;
        mask_next = '1;
      end else if (tb_b >= 8'hC0) begin
        mode_next = M_UTF;
        u0_next = tb_b;
        urem_next = 2'(seq_len(tb_b) - 3'd1);
      end else begin
        em_req = 1'b1;
        em.bytes[0] = tb_b;
        em.len = 3'd1;
      end
    end

    capv = (capacity == '0) ? 16'd1 : capacity;
    need = {1'b0, used} + 17'(em.len) + 17'd1;
    fits = need <= {1'b0, capv};
    if (em_req) begin
      if (fits) begin
        q_push = adv;
        q_data = em;
        used_next = need[15:0] - 16'd1;
      end else begin
        mode_next = M_STOP;
      end
    end
    if (term_req) begin
      q_push = adv;
      q_data = '0;
      q_data.len = 3'd1;
      q_data.term = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      mode <= M_TEXT;
      capacity <= CAP_RESET;
      cnt <= '0;  ridx <= '0;  urem <= '0;  used <= '0;
      val <= '0;  hex <= 1'b0;  num <= 1'b0;  mask <= '1;
      lastfail <= 1'b0;  cur_last <= 1'b0;
    end else begin
      if (cfg_valid) capacity <= cfg_data;
      if (adv) begin
        st <= st_next;  mode <= mode_next;  cnt <= cnt_next;  ridx <= ridx_next;
        urem <= urem_next;  used <= used_next;  val <= val_next;
        hex <= hex_next;  num <= num_next;  mask <= mask_next;
        lastfail <= lastfail_next;  cur_last <= cur_last_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u0 <= u0_next;  u1 <= u1_next;  u2 <= u2_next;  cur_c <= cur_c_next;
      if (la_we) la[cnt] <= c;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cnt} < (CW+1)'(REF_LIMIT)) else $error("lookahead count overflow");
  a_term_clear: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_data.term) |=> (used == '0 && mode == M_TEXT && st == S_IDLE))
    else $error("text state not cleared after terminator");

endmodule

// ===== src/hedts_fifo.sv =====
module hedts_fifo import hedts_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wdata,
  output logic full_q,
  input  logic rd,
  output logic avail,
  output cmd_t rdata
);

  localparam int AW = $clog2(DEPTH);

  cmd_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic do_wr, do_rd;

  assign full_q = count == (AW+1)'(DEPTH);
  assign avail  = count != '0;
  assign rdata  = mem[rp];
  assign do_wr  = wr && !full_q;
  assign do_rd  = rd && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (do_rd) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wdata;
  end

endmodule

// ===== src/hedts_back.sv =====
module hedts_back import hedts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_avail,
  input  cmd_t q_data,
  output logic q_pop,
  output logic empty,
  input  logic pop,
  output out_t out_item
);

  cmd_t cur;
  logic cv, ov, slot, last_b;
  logic [1:0] idx;

  assign slot   = !ov || pop;
  assign last_b = {1'b0, idx} == cur.len - 3'd1;
  assign q_pop  = q_avail && (!cv || (slot && last_b));
  assign empty  = !ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
      ov <= 1'b0;
      idx <= '0;
    end else begin
      if (slot) begin
        ov <= cv;
        if (cv) begin
          if (last_b) cv <= 1'b0;
          else idx <= idx + 2'd1;
        end
      end
      if (q_pop) begin
        cv <= 1'b1;
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot && cv) begin
      out_item.out_byte    <= cur.bytes[idx];
      out_item.end_of_text <= cur.term;
    end
    if (q_pop) cur <= q_data;
  end

endmodule

// ===== src/html_entity_decoder_tag_stripper.sv =====
// Input: one beat per cycle for text, tags and references while the queue has room;
// a failed reference holds full while '&' and its buffered bytes are replayed, and the
// last byte holds it while the terminator is queued. Output: one byte per cycle while
// pop is given; a multi-byte item is sent byte by byte before the next item is taken.
// Reset (rst, synchronous): text state cleared, queue emptied, capacity back to 256.
module html_entity_decoder_tag_stripper import hedts_pkg::*; #(
  parameter int MAX_REF = MAX_REF_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         in_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output out_t        out_item
);

  // front: parser FSM, reference judge, capacity accounting
  // queue: QDEPTH (4) whole items (1..4 bytes or terminator)
  // back: serializes items into output beats through an output register
  logic q_push, q_full, q_avail, q_pop;
  cmd_t q_wdata, q_rdata;

  hedts_front #(.MAX_REF(MAX_REF)) u_front (
    .clk, .rst, .push, .full, .in_item,
    .cfg_valid, .cfg_ready, .cfg_data,
    .q_push, .q_data(q_wdata), .q_full
  );

  hedts_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk, .rst,
    .wr(q_push), .wdata(q_wdata), .full_q(q_full),
    .rd(q_pop), .avail(q_avail), .rdata(q_rdata)
  );

  hedts_back u_back (
    .clk, .rst,
    .q_avail, .q_data(q_rdata), .q_pop,
    .empty, .pop, .out_item
  );

endmodule
